// ----- design/srtc_pkg.sv -----
package srtc_pkg;

    localparam int          COLUMN_LIMIT_DEF = 255;
    localparam int          RUN_WIDTH        = 8;
    localparam logic [7:0]  RUN_MAX          = 8'd255;

    localparam logic [7:0]  CH_BS    = 8'o010;
    localparam logic [7:0]  CH_TAB   = 8'o011;
    localparam logic [7:0]  CH_NL    = 8'o012;
    localparam logic [7:0]  CH_ESC   = 8'o033;
    localparam logic [7:0]  CH_SPACE = 8'o040;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_FINAL
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic flush_step;
        logic final_step;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic stay_idle;   // counted space: no result, no further work
        logic need_flush;  // pending run is nonzero after the pre-step
        logic run_done;    // this flush step empties the run
        logic can_step;    // output register free or item invisible
    } dp_status_t;

endpackage

// ----- design/space_run_to_tab_compressor_unit.sv -----
// Steps: an accepted item goes from idle to the flush state if a run is pending, where
//   each flush step takes one tab or space off the run (one flush step per cycle while
//   the output register is free or the item is invisible), then to the final step; a new
//   item is taken only in idle. A space outside pass mode is absorbed with no result.
// Reset (rst_n, asynchronous, active low): column, pending run, separator and output
//   valid clear to zero; the controller returns to idle.
module space_run_to_tab_compressor_unit #(
    parameter int COLUMN_LIMIT = srtc_pkg::COLUMN_LIMIT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       visible,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       last
);
    import srtc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    srtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    srtc_datapath #(
        .COLUMN_LIMIT (COLUMN_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .char_in   (char_in),
        .visible   (visible),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- design/srtc_ctrl.sv -----
module srtc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  srtc_pkg::dp_status_t status,
    output srtc_pkg::ctrl_cmd_t  cmd
);
    import srtc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    priority if (status.stay_idle)
                        state_next = ST_IDLE;
                    else if (status.need_flush)
                        state_next = ST_FLUSH;
                    else
                        state_next = ST_FINAL;
                end
            end
            ST_FLUSH:
            begin
                if (status.can_step)
                begin
                    cmd.flush_step = 1'b1;
                    if (status.run_done)
                        state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (status.can_step)
                begin
                    cmd.final_step = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/srtc_datapath.sv -----
module srtc_datapath #(
    parameter int COLUMN_LIMIT = srtc_pkg::COLUMN_LIMIT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data,
    input  logic [7:0]          char_in,
    input  logic                visible,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          char_out,
    output logic                last,
    input  srtc_pkg::ctrl_cmd_t  cmd,
    output srtc_pkg::dp_status_t status
);
    import srtc_pkg::*;

    localparam int CW = $clog2(COLUMN_LIMIT + 1);
    localparam int WW = (CW > RUN_WIDTH) ? CW : RUN_WIDTH;
    localparam logic [CW-1:0] LIMIT = CW'(COLUMN_LIMIT);

    logic [7:0]           sep_reg;
    logic [CW-1:0]        col_reg;
    logic [RUN_WIDTH-1:0] pend_reg;
    logic [7:0]           char_reg;
    logic                 vis_reg;
    logic                 pass_reg;
    logic                 out_valid_reg;
    logic [7:0]           out_char_reg;
    logic                 out_last_reg;

    logic                 pass_mode;
    logic                 is_space;
    logic [CW-1:0]        sp_col;
    logic [RUN_WIDTH-1:0] sp_pend;
    logic [CW-1:0]        pre_col;
    logic [RUN_WIDTH-1:0] pre_pend;
    logic [RUN_WIDTH-1:0] clamp_pend;
    logic [WW-1:0]        col_ext;
    logic [WW-1:0]        pend_ext;
    logic [WW-1:0]        stop;
    logic [WW-1:0]        tab_rem;
    logic                 use_tab;
    logic [RUN_WIDTH-1:0] step_pend;
    logic                 slot_free;

    assign pass_mode = (sep_reg != 8'd0);
    assign is_space  = (char_in == CH_SPACE);
    assign col_ext   = WW'(col_reg);
    assign pend_ext  = WW'(pend_reg);

    // Space: advance column (saturating), grow run up to column and run max
    assign sp_col  = (col_reg < LIMIT) ? (col_reg + CW'(1)) : col_reg;
    assign sp_pend = ((pend_reg != RUN_MAX) && (pend_ext < WW'(sp_col)))
                     ? (pend_reg + RUN_WIDTH'(1)) : pend_reg;

    always_comb
    begin
        pre_col  = col_reg;
        pre_pend = pend_reg;
        priority if (char_in == CH_NL)
        begin
            pre_col  = '0;
            pre_pend = '0;
        end
        else if ((char_in == CH_BS) || (char_in == CH_ESC))
        begin
            pre_col  = (col_reg != '0) ? (col_reg - CW'(1)) : col_reg;
            pre_pend = (pend_reg != '0) ? (pend_reg - RUN_WIDTH'(1)) : pend_reg;
        end
        else
        begin
            pre_col  = col_reg;
            pre_pend = pend_reg;
        end
    end

    // Run never extends past the column
    assign clamp_pend = (WW'(pre_pend) > WW'(pre_col)) ? RUN_WIDTH'(pre_col) : pre_pend;

    // One flush step: tab to the next 8-column stop, or a single space
    assign stop      = (col_ext - pend_ext) | WW'(7);
    assign use_tab   = (pend_reg > RUN_WIDTH'(2)) && (col_ext > stop);
    assign tab_rem   = col_ext - stop - WW'(1);
    assign step_pend = use_tab ? RUN_WIDTH'(tab_rem) : (pend_reg - RUN_WIDTH'(1));

    assign slot_free = !out_valid_reg || out_ready;

    assign status.stay_idle  = is_space && !pass_mode;
    assign status.need_flush = (clamp_pend != '0) && !pass_mode;
    assign status.run_done   = (step_pend == '0);
    assign status.can_step   = slot_free || !vis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg       <= '0;
            col_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                sep_reg <= cfg_data;

            // A new result takes the slot; otherwise drop valid after its transfer
            if ((cmd.flush_step || cmd.final_step) && vis_reg)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.accept && !pass_mode)
            begin
                if (is_space)
                begin
                    col_reg  <= sp_col;
                    pend_reg <= sp_pend;
                end
                else
                begin
                    col_reg  <= pre_col;
                    pend_reg <= clamp_pend;
                end
            end

            if (cmd.flush_step)
            begin
                pend_reg <= step_pend;
            end

            if (cmd.final_step)
            begin
                if (!pass_reg && (char_reg >= CH_SPACE) && (col_reg < LIMIT))
                    col_reg <= col_reg + CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg <= char_in;
            vis_reg  <= visible;
            pass_reg <= pass_mode;
        end
        if (cmd.flush_step && vis_reg)
        begin
            out_char_reg <= use_tab ? CH_TAB : CH_SPACE;
            out_last_reg <= 1'b0;
        end
        if (cmd.final_step && vis_reg)
        begin
            out_char_reg <= char_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = out_char_reg;
    assign last      = out_last_reg;

endmodule

// ----- design/srtc_checker.sv -----
module srtc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] char_out,
    input logic       last
);
    import srtc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(char_out) && $stable(last))
        else $error("result changed while stalled");

    // Only flushed tabs and spaces come before the final result
    a_flush_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> (char_out == CH_TAB) || (char_out == CH_SPACE))
        else $error("non-final result is not a tab or space");

    // No new item while an item's results are still partial
    a_no_accept_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready before final result of item");

endmodule

bind space_run_to_tab_compressor_unit srtc_checker u_srtc_checker (.*);
